/* rtl/scoc_pkg.sv */
`default_nettype none

package scoc_pkg;

  // Default coordinate width; the top level may override it in 8..24.
  localparam int COORD_BITS_DEFAULT = 16;

  // Configuration port
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_START_X = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_X   = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_Y   = CFG_INDEX_BITS'(3);

  // Load enables for the two register stages of the split multiplier
  typedef struct packed {
    logic part;   // partial product stage
    logic sum;    // recombination stage
  } mul_en_t;

endpackage

`default_nettype wire

/* rtl/scoc_wide_mul.sv */
`default_nettype none

// Unsigned multiplier cut into four half-width partial products, registered,
// then recombined in a second register stage.
module scoc_wide_mul #(
  parameter int A_BITS = 33,
  parameter int B_BITS = 33
) (
  input  wire logic                       clk,
  input  wire scoc_pkg::mul_en_t          en,
  input  wire logic [A_BITS-1:0]          a,
  input  wire logic [B_BITS-1:0]          b,
  output logic      [A_BITS+B_BITS-1:0]   p
);

  localparam int A_LO   = (A_BITS + 1) / 2;
  localparam int A_HI   = A_BITS - A_LO;
  localparam int B_LO   = (B_BITS + 1) / 2;
  localparam int B_HI   = B_BITS - B_LO;
  localparam int P_BITS = A_BITS + B_BITS;

  logic [A_HI+B_HI-1:0] pp_hh;
  logic [A_HI+B_LO-1:0] pp_hl;
  logic [A_LO+B_HI-1:0] pp_lh;
  logic [A_LO+B_LO-1:0] pp_ll;

  always_ff @(posedge clk) begin
    if (en.part) begin
      pp_hh <= (A_HI+B_HI)'(a[A_BITS-1:A_LO]) * (A_HI+B_HI)'(b[B_BITS-1:B_LO]);
      pp_hl <= (A_HI+B_LO)'(a[A_BITS-1:A_LO]) * (A_HI+B_LO)'(b[B_LO-1:0]);
      pp_lh <= (A_LO+B_HI)'(a[A_LO-1:0]) * (A_LO+B_HI)'(b[B_BITS-1:B_LO]);
      pp_ll <= (A_LO+B_LO)'(a[A_LO-1:0]) * (A_LO+B_LO)'(b[B_LO-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      p <= (P_BITS'(pp_hh) << (A_LO + B_LO))
         + (P_BITS'(pp_hl) << A_LO)
         + (P_BITS'(pp_lh) << B_LO)
         + P_BITS'(pp_ll);
    end
  end

endmodule

`default_nettype wire

/* rtl/segment_circle_obstacle_check_top.sv */
// Path: a circle item accepted into stage 1 moves through stages 2 to 6 and then into
//   the result register; the verdict of a last circle is shown from then on until taken.
// Throughput: one circle item per cycle while circle_stall is low, set by a six-stage pipeline with no shared unit.
// Reset (rst, synchronous, active high): segment registers to zero, blocked flag clear,
//   pipeline and result register empty.
`default_nettype none

module segment_circle_obstacle_check_top #(
  parameter int COORD_BITS = scoc_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration write port
  input  wire logic                                  cfg_write,
  input  wire logic [scoc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [COORD_BITS-1:0]                 cfg_data,
  // circle items
  input  wire logic                                  circle_valid,
  output logic                                       circle_stall,
  input  wire logic signed [COORD_BITS-1:0]          circle_x,
  input  wire logic signed [COORD_BITS-1:0]          circle_y,
  input  wire logic [COORD_BITS-1:0]                 radius,
  input  wire logic                                  last_circle,
  // verdict items
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic                                       path_clear
);

  // Widths. Coordinate differences need one bit more than a coordinate; a
  // product of two differences has magnitude below 2^(2N), so a signed
  // product fits 2N+1 bits and a sum of two fits 2N+2. Sums of squares and
  // the cross magnitude are below 2^(2N+1).
  localparam int DW = COORD_BITS + 1;       // signed difference
  localparam int PW = 2 * COORD_BITS + 1;   // signed product
  localparam int QW = 2 * COORD_BITS;       // square, unsigned
  localparam int SW = 2 * COORD_BITS + 2;   // signed dot / cross
  localparam int UW = 2 * COORD_BITS + 1;   // unsigned sum of squares
  localparam int CW = 2 * UW;               // cross^2
  localparam int RW = QW + UW;              // r^2 * L

  // ---------------------------------------------------------------------------
  // Segment registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      end_x   <= '0;
      end_y   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        scoc_pkg::REG_START_X: start_x <= cfg_data;
        scoc_pkg::REG_START_Y: start_y <= cfg_data;
        scoc_pkg::REG_END_X:   end_x   <= cfg_data;
        scoc_pkg::REG_END_Y:   end_y   <= cfg_data;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. Each stage loads whenever it is empty or its item moves on,
  // so bubbles collapse. Stage six retires into the result register; only a
  // last circle needs that register, other items retire regardless.
  // ---------------------------------------------------------------------------
  logic [6:1] v;
  logic [6:1] rdy;
  logic       s6_last;
  logic       adv6;
  logic       retire;

  assign adv6   = !s6_last || !result_valid || !result_stall;
  assign retire = v[6] && adv6;

  always_comb begin
    rdy[6] = !v[6] || adv6;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign circle_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= circle_valid;
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
      if (rdy[5]) v[5] <= v[4];
      if (rdy[6]) v[6] <= v[5];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: differences w = c-a, u = c-b, v = b-a
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] cx_e, cy_e, ax_e, ay_e, bx_e, by_e;

  assign cx_e = {circle_x[COORD_BITS-1], circle_x};
  assign cy_e = {circle_y[COORD_BITS-1], circle_y};
  assign ax_e = {start_x[COORD_BITS-1], start_x};
  assign ay_e = {start_y[COORD_BITS-1], start_y};
  assign bx_e = {end_x[COORD_BITS-1], end_x};
  assign by_e = {end_y[COORD_BITS-1], end_y};

  logic signed [DW-1:0] s1_wx, s1_wy, s1_ux, s1_uy, s1_vx, s1_vy;
  logic [COORD_BITS-1:0] s1_r;
  logic                  s1_last;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_wx   <= cx_e - ax_e;
      s1_wy   <= cy_e - ay_e;
      s1_ux   <= cx_e - bx_e;
      s1_uy   <= cy_e - by_e;
      s1_vx   <= bx_e - ax_e;
      s1_vy   <= by_e - ay_e;
      s1_r    <= radius;
      s1_last <= last_circle;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: all small products in parallel, r*r N x N and the rest (N+1) x (N+1)
  // ---------------------------------------------------------------------------
  logic signed [2*DW-1:0] m_tx, m_ty, m_ca, m_cb;
  logic signed [2*DW-1:0] m_vxx, m_vyy, m_wxx, m_wyy, m_uxx, m_uyy;
  logic [QW-1:0]          m_rr;

  assign m_tx  = s1_wx * s1_vx;
  assign m_ty  = s1_wy * s1_vy;
  assign m_ca  = s1_wx * s1_vy;
  assign m_cb  = s1_wy * s1_vx;
  assign m_vxx = s1_vx * s1_vx;
  assign m_vyy = s1_vy * s1_vy;
  assign m_wxx = s1_wx * s1_wx;
  assign m_wyy = s1_wy * s1_wy;
  assign m_uxx = s1_ux * s1_ux;
  assign m_uyy = s1_uy * s1_uy;
  assign m_rr  = QW'(s1_r) * QW'(s1_r);

  logic signed [PW-1:0] s2_tx, s2_ty, s2_ca, s2_cb;
  logic [QW-1:0]        s2_vxx, s2_vyy, s2_wxx, s2_wyy, s2_uxx, s2_uyy, s2_rr;
  logic                 s2_last;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_tx   <= m_tx[PW-1:0];
      s2_ty   <= m_ty[PW-1:0];
      s2_ca   <= m_ca[PW-1:0];
      s2_cb   <= m_cb[PW-1:0];
      s2_vxx  <= m_vxx[QW-1:0];   // squares are non-negative and below 2^(2N)
      s2_vyy  <= m_vyy[QW-1:0];
      s2_wxx  <= m_wxx[QW-1:0];
      s2_wyy  <= m_wyy[QW-1:0];
      s2_uxx  <= m_uxx[QW-1:0];
      s2_uyy  <= m_uyy[QW-1:0];
      s2_rr   <= m_rr;
      s2_last <= s1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: t = w.v, cross = w x v, L = |v|^2, |c-a|^2, |c-b|^2
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] s3_t, s3_crs;
  logic [UW-1:0]        s3_len2, s3_da2, s3_db2;
  logic [QW-1:0]        s3_r2;
  logic                 s3_last;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_t    <= {s2_tx[PW-1], s2_tx} + {s2_ty[PW-1], s2_ty};
      s3_crs  <= {s2_ca[PW-1], s2_ca} - {s2_cb[PW-1], s2_cb};
      s3_len2 <= {1'b0, s2_vxx} + {1'b0, s2_vyy};
      s3_da2  <= {1'b0, s2_wxx} + {1'b0, s2_wyy};
      s3_db2  <= {1'b0, s2_uxx} + {1'b0, s2_uyy};
      s3_r2   <= s2_rr;
      s3_last <= s2_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: pick the region, settle the end-point tests, |cross|.
  // A zero-length segment gives t = 0 and lands in the start-point region.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] crs_neg;
  logic [UW-1:0]        cr_abs;
  logic                 near_sel, far_sel, near_hit, far_hit;

  always_comb begin
    crs_neg  = -s3_crs;
    cr_abs   = s3_crs[SW-1] ? crs_neg[UW-1:0] : s3_crs[UW-1:0];
    near_sel = s3_t[SW-1] || (s3_t == '0);
    far_sel  = !near_sel && (s3_t >= $signed({1'b0, s3_len2}));
    near_hit = s3_da2 < {1'b0, s3_r2};
    far_hit  = s3_db2 < {1'b0, s3_r2};
  end

  logic          s4_near, s4_far, s4_nh, s4_fh, s4_last;
  logic [UW-1:0] s4_cr, s4_len2;
  logic [QW-1:0] s4_r2;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_near <= near_sel;
      s4_far  <= far_sel;
      s4_nh   <= near_hit;
      s4_fh   <= far_hit;
      s4_last <= s3_last;
      s4_cr   <= cr_abs;
      s4_len2 <= s3_len2;
      s4_r2   <= s3_r2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5 and 6: cross^2 and r^2 * L through split multipliers
  // ---------------------------------------------------------------------------
  scoc_pkg::mul_en_t mul_en;
  logic [CW-1:0]     lhs;
  logic [RW-1:0]     rhs;

  assign mul_en.part = rdy[5];
  assign mul_en.sum  = rdy[6];

  scoc_wide_mul #(
    .A_BITS (UW),
    .B_BITS (UW)
  ) u_cross_sq (
    .clk (clk),
    .en  (mul_en),
    .a   (s4_cr),
    .b   (s4_cr),
    .p   (lhs)
  );

  scoc_wide_mul #(
    .A_BITS (QW),
    .B_BITS (UW)
  ) u_rad_len (
    .clk (clk),
    .en  (mul_en),
    .a   (s4_r2),
    .b   (s4_len2),
    .p   (rhs)
  );

  logic s5_near, s5_far, s5_nh, s5_fh, s5_last;
  logic s6_near, s6_far, s6_nh, s6_fh;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_near <= s4_near;
      s5_far  <= s4_far;
      s5_nh   <= s4_nh;
      s5_fh   <= s4_fh;
      s5_last <= s4_last;
    end
    if (rdy[6]) begin
      s6_near <= s5_near;
      s6_far  <= s5_far;
      s6_nh   <= s5_nh;
      s6_fh   <= s5_fh;
      s6_last <= s5_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Retire: interior test, sticky blocked flag, verdict on a last circle.
  // Touching (equal distance) does not block; nor does a zero radius.
  // ---------------------------------------------------------------------------
  logic hit;
  logic blocked;

  always_comb begin
    priority if (s6_near) begin
      hit = s6_nh;
    end else if (s6_far) begin
      hit = s6_fh;
    end else begin
      hit = lhs < {{(CW-RW){1'b0}}, rhs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (retire) begin
        if (s6_last) begin
          blocked      <= 1'b0;
          result_valid <= 1'b1;
        end else begin
          blocked <= blocked || hit;
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (retire && !s6_last && result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (retire && s6_last) begin
      path_clear <= !(blocked || hit);
    end
  end

endmodule

`default_nettype wire

/* verif/segment_circle_obstacle_check_top_test.sv */
module segment_circle_obstacle_check_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Coordinate width used throughout the bench; the block runs at its default.
  localparam int COORD_BITS = scoc_pkg::COORD_BITS_DEFAULT;

  localparam logic signed [15:0] COORD_MIN = 16'sh8000;
  localparam logic signed [15:0] COORD_MAX = 16'sh7fff;
  localparam logic [15:0]        RADIUS_MAX = 16'hffff;

  // Highest register index the write port can carry.
  localparam int INDEX_TOP = (1 << scoc_pkg::CFG_INDEX_BITS) - 1;

  // Verdict column of the directed table: a fixed value, or left to the predictor.
  localparam int VERDICT_PREDICTED = -1;
  localparam int VERDICT_BLOCKED   = 0;
  localparam int VERDICT_CLEAR     = 1;

  // Wait for the pipeline to empty before touching registers.
  localparam int SETTLE_CYCLES   = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_ITEMS    = 1950;

  // ---------------------------------------------------------------------------
  // Block under test
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [scoc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0] cfg_data;
  logic circle_valid;
  logic circle_stall;
  logic signed [COORD_BITS-1:0] circle_x;
  logic signed [COORD_BITS-1:0] circle_y;
  logic [COORD_BITS-1:0] radius;
  logic last_circle;
  logic result_valid;
  logic result_stall;
  logic path_clear;

  segment_circle_obstacle_check_top #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .circle_valid(circle_valid),
    .circle_stall(circle_stall),
    .circle_x(circle_x),
    .circle_y(circle_y),
    .radius(radius),
    .last_circle(last_circle),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .path_clear(path_clear)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: segment registers, sticky blocked flag, verdicts due
  // ---------------------------------------------------------------------------
  logic signed [15:0] seg_ax, seg_ay, seg_bx, seg_by;
  bit blocked_so_far;
  bit clear_due[$];    // verdicts still to come out, oldest first

  int errors;
  int items_taken;
  bit tx_idle;         // sender draws gaps between items
  bit rx_idle;         // receiver draws stalls between items
  bit hold_off_req;    // asks the receiver for one long hold-off

  // Exact integer test of one circle against the current segment. Products run
  // past 64 bits in the interior case, so that comparison is done at 128.
  function automatic logic circle_blocks_segment(input logic signed [15:0] cx_in,
                                                 input logic signed [15:0] cy_in,
                                                 input logic [15:0] r_in);
    longint ax, ay, bx, by, cx, cy;
    longint vx, vy, wx, wy, t, len2, crs;
    logic [127:0] r2, lhs, rhs;
    ax = seg_ax;
    ay = seg_ay;
    bx = seg_bx;
    by = seg_by;
    cx = cx_in;
    cy = cy_in;
    vx = bx - ax;
    vy = by - ay;
    wx = cx - ax;
    wy = cy - ay;
    t = wx * vx + wy * vy;
    len2 = vx * vx + vy * vy;
    r2 = 128'(r_in) * 128'(r_in);
    // behind a (also covers the zero-length segment, where t is 0)
    if (t <= 0) return 128'(wx * wx + wy * wy) < r2;
    // beyond b
    if (t >= len2) return 128'((cx - bx) * (cx - bx) + (cy - by) * (cy - by)) < r2;
    // alongside: squared distance to the line, scaled by |v|^2
    crs = wx * vy - wy * vx;
    if (crs < 0) crs = -crs;
    lhs = 128'(crs) * 128'(crs);
    rhs = r2 * 128'(len2);
    return lhs < rhs;
  endfunction

  function automatic logic signed [15:0] any_coord();
    return $signed(16'($urandom));
  endfunction

  function automatic logic signed [15:0] clamp_coord(input int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return 16'(v);
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_CIRCLE, ROW_SEGMENT, ROW_STRAY} row_kind_t;

  // circle: p, q = centre, r = radius; segment: p, q = a, s, u = b;
  // stray write: r = register index, p = data
  typedef struct packed {
    row_kind_t kind;
    logic signed [15:0] p, q, s, u;
    logic [15:0] r;
    logic is_last;
    logic signed [7:0] verdict;
  } stim_row_t;

  function automatic stim_row_t circle_row(input int x, input int y, input int r,
                                           input bit is_last, input int verdict);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CIRCLE;
    row.p = 16'(x);
    row.q = 16'(y);
    row.r = 16'(r);
    row.is_last = is_last;
    row.verdict = 8'(verdict);
    return row;
  endfunction

  function automatic stim_row_t segment_row(input int ax, input int ay,
                                            input int bx, input int by);
    stim_row_t row;
    row = '0;
    row.kind = ROW_SEGMENT;
    row.p = 16'(ax);
    row.q = 16'(ay);
    row.s = 16'(bx);
    row.u = 16'(by);
    return row;
  endfunction

  function automatic stim_row_t stray_row(input int index, input int data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_STRAY;
    row.r = 16'(index);
    row.p = 16'(data);
    return row;
  endfunction

  stim_row_t script [24];

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------

  // One register write; the caller lowers cfg_write after its last write.
  task automatic write_reg(input logic [scoc_pkg::CFG_INDEX_BITS-1:0] index,
                           input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    case (index)
      scoc_pkg::REG_START_X: seg_ax = data;
      scoc_pkg::REG_START_Y: seg_ay = data;
      scoc_pkg::REG_END_X:   seg_bx = data;
      scoc_pkg::REG_END_Y:   seg_by = data;
      default: ;   // out of range: ignored
    endcase
  endtask

  // Offer one circle item and hold it until taken; update the shadow on acceptance.
  task automatic offer_circle(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic [15:0] r, input logic is_last, input int verdict);
    int gap;
    logic hit;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      circle_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    circle_x     <= x;
    circle_y     <= y;
    radius       <= r;
    last_circle  <= is_last;
    circle_valid <= 1'b1;
    @(posedge clk);
    while (circle_stall) @(posedge clk);
    hit = circle_blocks_segment(x, y, r);
    blocked_so_far = blocked_so_far | hit;
    if (is_last) begin
      clear_due.push_back(verdict == VERDICT_PREDICTED ? !blocked_so_far : verdict[0]);
      blocked_so_far = 1'b0;
    end
    items_taken++;
  endtask

  // Drop valid, wait for every verdict, then let the pipeline empty of
  // non-last items before registers may change.
  task automatic settle();
    circle_valid <= 1'b0;
    while (clear_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random circle, weighted towards the segment so both verdicts turn up.
  task automatic pick_circle(output logic signed [15:0] x, output logic signed [15:0] y,
                             output logic [15:0] r);
    int k, span, px, py;
    case ($urandom_range(0, 5))
      0: begin
        // anywhere, any radius: every bit of every field
        x = any_coord();
        y = any_coord();
        r = 16'($urandom);
      end
      1: begin
        x = any_coord();
        y = any_coord();
        r = 16'($urandom_range(0, 255));
      end
      2, 3: begin
        // near a point along the segment, radius around the offset
        k = $urandom_range(0, 16);
        span = $urandom_range(0, 3000);
        px = seg_ax + ((seg_bx - seg_ax) * k) / 16;
        py = seg_ay + ((seg_by - seg_ay) * k) / 16;
        x = clamp_coord(px + jitter(span));
        y = clamp_coord(py + jitter(span));
        r = 16'($urandom_range(0, span + span / 2 + 2));
      end
      4: begin
        // close to an end point
        if ($urandom_range(0, 1)) begin
          px = seg_ax;
          py = seg_ay;
        end else begin
          px = seg_bx;
          py = seg_by;
        end
        span = $urandom_range(0, 40);
        x = clamp_coord(px + jitter(span));
        y = clamp_coord(py + jitter(span));
        r = 16'($urandom_range(0, 60));
      end
      default: begin
        // zero radius never blocks
        x = any_coord();
        y = any_coord();
        r = '0;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off on request, verdict check
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    bit want;
    hold = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall) begin
        if (clear_due.size() == 0) begin
          $error("path_clear: expected no item, got %0b", path_clear);
          errors++;
        end else begin
          want = clear_due.pop_front();
          if (path_clear !== want) begin
            $error("path_clear: expected %0b, got %0b", want, path_clear);
            errors++;
          end
        end
        hold = rx_idle ? $urandom_range(0, 7) : 0;
      end
      // long hold-off so the pipeline backs up and stalls the sender
      if (hold_off_req) begin
        hold = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles without any item moving on either side
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (circle_valid && !circle_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic signed [15:0] ax, ay, bx, by, x, y;
    logic [15:0] r;
    int len, phase, span;

    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    circle_valid <= 1'b0;
    circle_x     <= '0;
    circle_y     <= '0;
    radius       <= '0;
    last_circle  <= 1'b0;
    seg_ax = '0;
    seg_ay = '0;
    seg_bx = '0;
    seg_by = '0;
    blocked_so_far = 1'b0;
    errors = 0;
    items_taken = 0;
    quiet_cycles = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_off_req = 1'b0;

    script = '{
      // segment out of reset is a point at the origin
      circle_row(0, 0, 0, 1'b1, VERDICT_CLEAR),          // zero radius
      circle_row(0, 0, 1, 1'b1, VERDICT_BLOCKED),
      circle_row(3, 4, 5, 1'b1, VERDICT_CLEAR),          // touching
      circle_row(3, 4, 6, 1'b0, VERDICT_PREDICTED),      // blocks, no verdict yet
      circle_row(COORD_MIN, COORD_MIN, 0, 1'b1, VERDICT_BLOCKED),  // sticky flag
      circle_row(COORD_MAX, COORD_MAX, RADIUS_MAX, 1'b1, VERDICT_BLOCKED),
      circle_row(COORD_MIN, COORD_MAX, RADIUS_MAX, 1'b1, VERDICT_BLOCKED),
      // full-range diagonal
      segment_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX),
      circle_row(0, 0, 1, 1'b1, VERDICT_PREDICTED),
      circle_row(COORD_MIN, COORD_MIN, 0, 1'b1, VERDICT_PREDICTED),
      circle_row(COORD_MAX, COORD_MIN, RADIUS_MAX, 1'b1, VERDICT_PREDICTED),
      circle_row(COORD_MAX, COORD_MAX, 1, 1'b1, VERDICT_PREDICTED),
      circle_row(COORD_MIN, COORD_MAX, 46341, 1'b1, VERDICT_PREDICTED),
      // the other diagonal
      segment_row(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX),
      circle_row(100, 100, RADIUS_MAX, 1'b0, VERDICT_PREDICTED),
      circle_row(0, 0, 0, 1'b1, VERDICT_PREDICTED),
      // short horizontal segment: interior and both ends, touching and not
      segment_row(-100, 0, 100, 0),
      circle_row(0, 5, 5, 1'b1, VERDICT_CLEAR),
      circle_row(0, 5, 6, 1'b1, VERDICT_BLOCKED),
      circle_row(-105, 0, 5, 1'b1, VERDICT_CLEAR),
      circle_row(104, 3, 5, 1'b1, VERDICT_CLEAR),
      circle_row(104, 3, 6, 1'b1, VERDICT_BLOCKED),
      // write to a missing register must leave the segment alone
      stray_row(INDEX_TOP, COORD_MAX),
      circle_row(0, 5, 5, 1'b1, VERDICT_PREDICTED)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_SEGMENT: begin
          settle();
          write_reg(scoc_pkg::REG_START_X, script[i].p);
          write_reg(scoc_pkg::REG_START_Y, script[i].q);
          write_reg(scoc_pkg::REG_END_X, script[i].s);
          write_reg(scoc_pkg::REG_END_Y, script[i].u);
          cfg_write <= 1'b0;
        end
        ROW_STRAY: begin
          settle();
          write_reg(script[i].r[scoc_pkg::CFG_INDEX_BITS-1:0], script[i].p);
          cfg_write <= 1'b0;
        end
        default:
          offer_circle(script[i].p, script[i].q, script[i].r, script[i].is_last,
                       script[i].verdict);
      endcase
    end

    // Random phases: new segment each time, then lists of one or more circles.
    items_taken = 0;
    phase = 0;
    while (items_taken < RANDOM_ITEMS) begin
      settle();
      ax = any_coord();
      ay = any_coord();
      bx = any_coord();
      by = any_coord();
      case ($urandom_range(0, 4))
        1: begin
          span = $urandom_range(1, 500);
          bx = clamp_coord(ax + jitter(span));
          by = clamp_coord(ay + jitter(span));
        end
        2: begin
          // zero length
          bx = ax;
          by = ay;
        end
        3: begin
          if ($urandom_range(0, 1)) by = ay;
          else bx = ax;
        end
        4: begin
          ax = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
          ay = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
          bx = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
          by = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
        end
        default: ;
      endcase
      write_reg(scoc_pkg::REG_START_X, ax);
      write_reg(scoc_pkg::REG_START_Y, ay);
      write_reg(scoc_pkg::REG_END_X, bx);
      write_reg(scoc_pkg::REG_END_Y, by);
      if ($urandom_range(0, 2) == 0)
        write_reg(scoc_pkg::CFG_INDEX_BITS'($urandom_range(scoc_pkg::REG_END_Y + 1,
                                                           INDEX_TOP)),
                  16'($urandom));
      cfg_write <= 1'b0;

      // a quarter of the phases run with no gaps on that side
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);

      // back-pressure: receiver holds off while a burst of verdicts is offered
      if (phase == 2) begin
        tx_idle = 1'b0;
        hold_off_req = 1'b1;
        repeat (48) begin
          pick_circle(x, y, r);
          offer_circle(x, y, r, 1'b1, VERDICT_PREDICTED);
        end
      end

      len = $urandom_range(40, 120);
      for (int i = 0; i < len; i++) begin
        pick_circle(x, y, r);
        offer_circle(x, y, r, (i == len - 1) || $urandom_range(0, 1), VERDICT_PREDICTED);
      end
      phase++;
    end

    settle();
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
